// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every check samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on its own at every sampled edge.
`define SPR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SPR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/spr_pkg.sv =====
package spr_pkg;

	localparam int SPR_MAX_PATTERN = 8;
	localparam int SPR_CFG_W       = 64;
	localparam int SPR_LEN_W       = 4;
	localparam int SPR_TOTAL_W     = 32;
	localparam int SPR_CFG_IDX_W   = 3;

	typedef enum logic [SPR_CFG_IDX_W-1:0] {
		REG_SEARCH_PATTERN  = 3'd0,
		REG_SEARCH_LENGTH   = 3'd1,
		REG_REPLACE_PATTERN = 3'd2,
		REG_REPLACE_LENGTH  = 3'd3,
		REG_FILL_MODE       = 3'd4
	} spr_reg_t;

	// Descriptor that travels with a job of result bytes into the emitter.
	typedef struct packed {
		logic                   rep;
		logic                   eos;
		logic                   bare;
		logic [SPR_TOTAL_W-1:0] total;
	} spr_info_t;

endpackage

// ===== rtl/stream_pattern_replace.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------------
// input    | in_valid / in_stall  | data_byte, end_of_stream
// output   | out_valid / out_stall| out_byte, byte_valid, is_replacement, last_of_run,
//          |                      | stream_done, match_total
// config   | cfg_we               | cfg_index, cfg_wdata (no wait, no read-back)
//
// An input byte that gives at most one result is taken every cycle while out_stall is low;
// a byte that gives k results holds in_stall until its last result is sent, as the emitter
// drains one result a cycle while out_stall is low. A result goes from the job register
// into the output register. Reset is asynchronous: it empties the window, clears the
// match count and the emitter, and sets the registers to their documented values.
// out_stall freezes the output register while it holds a result; in_stall rises only while an earlier result job
// cannot leave the emitter in the current cycle.
`include "assert_macros.svh"

module stream_pattern_replace import spr_pkg::*; #(
	parameter int MAX_PATTERN = SPR_MAX_PATTERN
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [SPR_CFG_IDX_W-1:0] cfg_index,
	input  logic [SPR_CFG_W-1:0]     cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               data_byte,
	input  logic                     end_of_stream,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               out_byte,
	output logic                     byte_valid,
	output logic                     is_replacement,
	output logic                     last_of_run,
	output logic                     stream_done,
	output logic [SPR_TOTAL_W-1:0]   match_total
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);

	// Configuration registers.
	logic [SPR_CFG_W-1:0]        search_pattern_q;
	logic [SPR_LEN_W-1:0]        search_length_q;
	logic [SPR_CFG_W-1:0]        replace_pattern_q;
	logic [SPR_LEN_W-1:0]        replace_length_q;
	logic                        fill_mode_q;

	// Window state: a fill count here, the bytes themselves live in the row of cells.
	logic [FILL_W-1:0]           fill_q;
	logic [SPR_TOTAL_W-1:0]      match_q;

	logic [MAX_PATTERN-1:0][7:0] win;
	logic [MAX_PATTERN-1:0][7:0] ext;
	logic [MAX_PATTERN-1:0][7:0] rep_vec;
	logic [MAX_PATTERN-1:0]      hit_vec;
	logic [MAX_PATTERN-1:0]      len_mask;
	logic [SPR_LEN_W-1:0]        len4;
	logic [SPR_LEN_W-1:0]        rl4;
	logic [FILL_W-1:0]           len_eff;
	logic [FILL_W-1:0]           rl_eff;
	logic [FILL_W-1:0]           rep_cnt;
	logic [FILL_W-1:0]           fill_ext;
	logic [FILL_W-1:0]           fill_n;
	logic [FILL_W-1:0]           shift;
	logic [FILL_W-1:0]           job_cnt;
	logic [MAX_PATTERN-1:0][7:0] job_bytes;
	logic [SPR_TOTAL_W-1:0]      match_n;
	spr_info_t                   job_info;
	logic                        hit_all;
	logic                        fill_ge;
	logic                        fill_gt;
	logic                        matched;
	logic                        has_job;
	logic                        job_ready;
	logic                        accept;
	logic                        job_load;

	// Configuration writes; an index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_pattern_q  <= '0;
			search_length_q   <= SPR_LEN_W'(1);
			replace_pattern_q <= '0;
			replace_length_q  <= '0;
			fill_mode_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEARCH_PATTERN:  search_pattern_q  <= cfg_wdata;
				REG_SEARCH_LENGTH:   search_length_q   <= cfg_wdata[SPR_LEN_W-1:0];
				REG_REPLACE_PATTERN: replace_pattern_q <= cfg_wdata;
				REG_REPLACE_LENGTH:  replace_length_q  <= cfg_wdata[SPR_LEN_W-1:0];
				REG_FILL_MODE:       fill_mode_q       <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Lengths are clamped: a search length of zero acts as one, and both lengths are
	// limited to the window depth.
	always_comb begin
		len4 = search_length_q;
		if (len4 == '0) begin
			len4 = SPR_LEN_W'(1);
		end else if (len4 > SPR_LEN_W'(MAX_PATTERN)) begin
			len4 = SPR_LEN_W'(MAX_PATTERN);
		end
		rl4 = (replace_length_q > SPR_LEN_W'(MAX_PATTERN)) ?
			SPR_LEN_W'(MAX_PATTERN) : replace_length_q;
	end

	assign len_eff = FILL_W'(len4);
	assign rl_eff  = FILL_W'(rl4);

	// The extended window is the stored window with the incoming byte placed at the fill
	// position. Each cell compares its slot of it against its byte of the search pattern
	// and, on a transfer, picks its new byte from it shifted by the drop amount.
	genvar gi;
	generate
		for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_row
			assign ext[gi]      = (fill_q == FILL_W'(gi)) ? data_byte : win[gi];
			assign len_mask[gi] = (FILL_W'(gi) < len_eff);
			assign rep_vec[gi]  = (FILL_W'(gi) < rl_eff) ?
				replace_pattern_q[8*gi +: 8] : 8'h00;

			spr_cell #(
				.MAX_PATTERN (MAX_PATTERN),
				.IDX         (gi)
			) u_cell (
				.clk   (clk),
				.load  (accept),
				.ext   (ext),
				.shift (shift),
				.pat   (search_pattern_q[8*gi +: 8]),
				.q     (win[gi]),
				.hit   (hit_vec[gi])
			);
		end
	endgenerate

	// Decision for one input byte. A full window that matches is replaced and dropped;
	// otherwise the oldest byte passes through. At end of stream any window that does not
	// end in a match is flushed whole, which also covers a window longer than a search
	// length that was shortened mid-stream. An end of stream that leaves nothing to send
	// gives a bare end marker.
	always_comb begin
		fill_ext = fill_q + FILL_W'(1);
		hit_all  = &(hit_vec | ~len_mask);
		fill_ge  = (fill_ext >= len_eff);
		fill_gt  = (fill_ext > len_eff);
		matched  = fill_ge && hit_all && !(end_of_stream && fill_gt);
		rep_cnt  = fill_mode_q ? len_eff : rl_eff;
		match_n  = match_q + SPR_TOTAL_W'(matched);

		has_job        = 1'b0;
		job_cnt        = fill_ext;
		job_bytes      = ext;
		job_info.rep   = 1'b0;
		job_info.eos   = end_of_stream;
		job_info.bare  = 1'b0;
		job_info.total = match_n;
		shift          = '0;
		fill_n         = fill_ext;

		if (matched) begin
			shift     = len_eff;
			fill_n    = fill_ext - len_eff;
			job_bytes = rep_vec;
			if (rep_cnt != '0) begin
				has_job      = 1'b1;
				job_cnt      = rep_cnt;
				job_info.rep = 1'b1;
			end else if (end_of_stream) begin
				has_job       = 1'b1;
				job_cnt       = FILL_W'(1);
				job_info.bare = 1'b1;
			end
		end else if (end_of_stream) begin
			has_job = 1'b1;
			job_cnt = fill_ext;
		end else if (fill_ge) begin
			has_job = 1'b1;
			job_cnt = FILL_W'(1);
			shift   = FILL_W'(1);
			fill_n  = fill_ext - FILL_W'(1);
		end

		if (end_of_stream) begin
			fill_n = '0;
		end
	end

	assign accept   = in_valid && job_ready;
	assign in_stall = !job_ready;
	assign job_load = accept && has_job;

	// The end of a stream empties the window and restarts the match count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			match_q <= '0;
		end else if (accept) begin
			fill_q  <= fill_n;
			match_q <= end_of_stream ? '0 : match_n;
		end
	end

	spr_emit #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_load       (job_load),
		.job_cnt        (job_cnt),
		.job_bytes      (job_bytes),
		.job_info       (job_info),
		.job_ready      (job_ready),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.is_replacement (is_replacement),
		.last_of_run    (last_of_run),
		.stream_done    (stream_done),
		.match_total    (match_total)
	);

	`SPR_ASSERT(a_fill_bound, fill_q < FILL_W'(MAX_PATTERN), "window fill reached its depth")
	`SPR_ASSERT_NEXT(a_eos_clears, accept && end_of_stream, (fill_q == '0) && (match_q == '0), "end of stream left state behind")

endmodule

// ===== rtl/spr_cell.sv =====
module spr_cell import spr_pkg::*; #(
	parameter int MAX_PATTERN = SPR_MAX_PATTERN,
	parameter int IDX         = 0
) (
	input  logic                            clk,
	input  logic                            load,
	input  logic [MAX_PATTERN-1:0][7:0]     ext,
	input  logic [$clog2(MAX_PATTERN+1)-1:0] shift,
	input  logic [7:0]                      pat,
	output logic [7:0]                      q,
	output logic                            hit
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [FILL_W:0] sel;
	logic [7:0]      q_n;

	// The cell compares its own position of the window after the new byte has gone in.
	assign hit = (ext[IDX] == pat);

	always_comb begin
		sel = (FILL_W + 1)'(IDX) + {1'b0, shift};
		if (sel < (FILL_W + 1)'(MAX_PATTERN)) begin
			q_n = ext[sel[IDX_W-1:0]];
		end else begin
			q_n = 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			q <= q_n;
		end
	end

endmodule

// ===== rtl/spr_emit.sv =====
`include "assert_macros.svh"

module spr_emit import spr_pkg::*; #(
	parameter int MAX_PATTERN = SPR_MAX_PATTERN
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_load,
	input  logic [$clog2(MAX_PATTERN+1)-1:0] job_cnt,
	input  logic [MAX_PATTERN-1:0][7:0]      job_bytes,
	input  spr_info_t                        job_info,
	output logic                             job_ready,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_byte,
	output logic                             byte_valid,
	output logic                             is_replacement,
	output logic                             last_of_run,
	output logic                             stream_done,
	output logic [SPR_TOTAL_W-1:0]           match_total
);

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);

	logic                          job_valid_q;
	logic [CNT_W-1:0]              job_cnt_q;
	logic [MAX_PATTERN-1:0][7:0]   job_q;
	spr_info_t                     info_q;
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          byte_valid_q;
	logic                          is_rep_q;
	logic                          last_q;
	logic                          done_q;
	logic [SPR_TOTAL_W-1:0]        total_q;
	logic                          out_free;
	logic                          move;
	logic                          job_last;

	assign out_free  = !out_valid_q || !out_stall;
	assign move      = job_valid_q && out_free;
	assign job_last  = (job_cnt_q == CNT_W'(1));
	assign job_ready = !job_valid_q || (out_free && job_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			job_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_load) begin
				job_valid_q <= 1'b1;
				job_cnt_q   <= job_cnt;
			end else if (move) begin
				job_cnt_q <= job_cnt_q - CNT_W'(1);
				if (job_last) begin
					job_valid_q <= 1'b0;
				end
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The job bytes form a chain: each cell hands its byte to its lower neighbour per result.
	always_ff @(posedge clk) begin
		if (job_load) begin
			job_q  <= job_bytes;
			info_q <= job_info;
		end else if (move) begin
			for (int i = 0; i < MAX_PATTERN - 1; i++) begin
				job_q[i] <= job_q[i+1];
			end
			job_q[MAX_PATTERN-1] <= 8'h00;
		end
		if (move) begin
			out_byte_q   <= job_q[0];
			byte_valid_q <= !info_q.bare;
			is_rep_q     <= info_q.rep;
			last_q       <= job_last;
			done_q       <= info_q.eos && job_last;
			total_q      <= (info_q.eos && job_last) ? info_q.total : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign byte_valid     = byte_valid_q;
	assign is_replacement = is_rep_q;
	assign last_of_run    = last_q;
	assign stream_done    = done_q;
	assign match_total    = total_q;

	`SPR_ASSERT_IMPL(a_job_cnt_nonzero, job_valid_q, job_cnt_q != '0, "job held with no results")
	`SPR_ASSERT_IMPL(a_no_overwrite, job_load, job_ready, "job loaded over a pending one")
	`SPR_ASSERT_NEXT(a_stalled_job_holds, job_valid_q && !out_free && !job_load, job_cnt_q == $past(job_cnt_q), "job count moved while stalled")

endmodule
